// ----- design/tli_pkg.sv -----
// tli_pkg: shared types, codes and fixed-point helpers for the table interpolator
// no dependencies

package tli_pkg;

    localparam int FRAC_BITS = 20;
    localparam int TIME_W    = 40;
    localparam int VAL_W     = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FEW      = 3'd1;
    localparam logic [2:0] ST_SPAN     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_GAP      = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic CFG_NUM_POINTS = 1'b0;
    localparam logic CFG_MAX_GAP    = 1'b1;

    localparam logic [31:0] NUM_POINTS_RST = 32'd8;
    localparam logic [31:0] MAX_GAP_RST    = 32'd3600000;

    localparam logic signed [63:0] MAG_LIMIT = 64'sd2147483647;
    localparam logic signed [64:0] ACC_LIMIT = 65'sd4611686018427387904;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_SRCH_A, S_SRCH_B, S_BEGIN, S_GAP,
        S_IPI, S_IPI_W, S_IPJ, S_IPJ_W, S_DIV, S_MUL, S_RND,
        S_TERM, S_ACC, S_FIN, S_DONE
    } state_t;

    // round(v / 2^FRAC_BITS), half away from zero
    function automatic logic signed [63:0] round_q(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat_mag(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > MAG_LIMIT)
            c = MAG_LIMIT;
        else if (v < -MAG_LIMIT)
            c = -MAG_LIMIT;
        else
            c = v;
        return c[31:0];
    endfunction

endpackage

// ----- design/tli_table_mem.sv -----
// tli_table_mem: entry time and value storage, one write and one registered read port
// depends on tli_pkg

module tli_table_mem
    import tli_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [TIME_W-1:0]       wtime,
    input  logic signed [VAL_W-1:0] wval,
    input  logic [AW-1:0]           raddr,
    output logic [TIME_W-1:0]       rtime,
    output logic signed [VAL_W-1:0] rval
);

    logic [TIME_W-1:0]       time_mem [2**AW];
    logic signed [VAL_W-1:0] val_mem  [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            time_mem[waddr] <= wtime;
            val_mem[waddr]  <= wval;
        end
        rtime <= time_mem[raddr];
        rval  <= val_mem[raddr];
    end

endmodule

// ----- design/tli_divider.sv -----
// tli_divider: restoring divider for the Lagrange factors, one quotient bit a cycle
// quotient saturates to 2^31-1; depends on tli_pkg

module tli_divider
    import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [60:0]       dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [30:0]       quot
);

    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] div_reg;
    logic [30:0]       sh_reg;
    logic [4:0]        cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [TIME_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, sh_reg[30]};
    assign ge    = trial >= {1'b0, div_reg};
    assign done  = done_reg;
    assign quot  = sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if ({10'd0, dividend[60:31]} >= divisor)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= 5'd30;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            if ({10'd0, dividend[60:31]} >= divisor)
                sh_reg <= '1;
            else
            begin
                rem_reg <= {10'd0, dividend[60:31]};
                sh_reg  <= dividend[30:0];
            end
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? TIME_W'(trial - {1'b0, div_reg}) : trial[TIME_W-1:0];
            sh_reg  <= {sh_reg[29:0], ge};
        end
    end

endmodule

// ----- design/table_lagrange_interpolator.sv -----
// table_lagrange_interpolator: top level, sequencer and fixed-point datapath
// depends on tli_pkg, tli_table_mem, tli_divider

// One item at a time; busy is high from acceptance until done. Every item
// gives exactly one result, shown for one cycle with done, which cannot be
// stalled. Clear, append, unused op and queries rejected by the count or span
// checks go straight to done. A query runs a bisection over the table memory,
// each probe through S_SRCH, S_SRCH_A and S_SRCH_B, places the window and scans
// it for gaps, then for each of the n(n-1) factor pairs runs the 31-step
// divider (cut short when the factor saturates), plus a term and accumulate
// step per point and a rounding step to finish.

module table_lagrange_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_POINTS  = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              op,
    input  logic [TIME_W-1:0]       time_ms,
    input  logic signed [VAL_W-1:0] entry_value,
    output logic                    done,
    output logic signed [VAL_W-1:0] result_value,
    output logic [2:0]              status,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [31:0]             cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]           count_reg;
    logic [3:0]              num_points_reg;
    logic [31:0]             max_gap_reg;
    logic [TIME_W-1:0]       first_reg, last_reg, t_reg, a_reg, prev_reg, gap_reg, ti_reg;
    logic [CW-1:0]           left_reg, right_reg, mid_reg, pos_reg, begin_reg;
    logic                    final_reg;
    logic [PW-1:0]           n_reg, k_reg, i_reg, j_reg;
    logic signed [VAL_W-1:0] vi_reg, w_reg, res_reg;
    logic signed [63:0]      prod_reg, acc_reg;
    logic [2:0]              status_reg;

    logic [PW-1:0]           n_eff;
    logic                    early_few, early_span, app_full, app_order, app_ok;
    logic [CW:0]             lr_sum;
    logic [CW-1:0]           mid_c;
    logic                    hit;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;
    logic [TIME_W-1:0]       rd_time;
    logic signed [VAL_W-1:0] rd_val;
    logic                    div_start, div_done;
    logic [30:0]             div_q;
    logic [TIME_W-1:0]       num_mag, den_mag;
    logic                    num_neg, den_neg;
    logic [60:0]             dividend;
    logic [CW:0]             half, halfup;
    logic signed [64:0]      acc_sum;
    logic signed [63:0]      fin_r;

    always_comb
    begin
        if (num_points_reg < 4'd2)
            n_eff = PW'(2);
        else if (32'(num_points_reg) > 32'(MAX_POINTS))
            n_eff = PW'(MAX_POINTS);
        else
            n_eff = PW'(num_points_reg);
    end

    assign early_few  = count_reg < CW'(n_eff);
    assign early_span = (time_ms < first_reg) || (time_ms > last_reg);
    assign app_full   = count_reg >= CW'(TABLE_DEPTH);
    assign app_order  = (count_reg != '0) && (time_ms <= last_reg);
    assign app_ok     = !app_full && !app_order;

    assign lr_sum = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid_c  = lr_sum[CW:1];
    assign hit    = (t_reg >= a_reg) && (t_reg <= rd_time);

    assign num_neg  = t_reg < rd_time;
    assign den_neg  = ti_reg < rd_time;
    assign num_mag  = num_neg ? rd_time - t_reg : t_reg - rd_time;
    assign den_mag  = den_neg ? rd_time - ti_reg : ti_reg - rd_time;
    assign dividend = {1'b0, num_mag, 20'd0} + 61'(den_mag >> 1);

    assign half    = (CW+1)'(n_reg >> 1);
    assign halfup  = (CW+1)'((n_reg + PW'(1)) >> 1);
    assign acc_sum = 65'(acc_reg) + 65'(prod_reg);
    assign fin_r   = round_q(acc_reg);

    logic                    fneg_reg;
    logic signed [VAL_W-1:0] fq;
    assign fq = fneg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    tli_table_mem #(.AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wtime (time_ms),
        .wval  (entry_value),
        .raddr (rd_addr),
        .rtime (rd_time),
        .rval  (rd_val)
    );

    tli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_mag),
        .done     (div_done),
        .quot     (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    if (op == OP_QUERY && !early_few && !early_span)
                        state_next = S_SRCH;
                    else
                        state_next = S_DONE;
                end
            S_SRCH:   state_next = (left_reg <= right_reg) ? S_SRCH_A : S_DONE;
            S_SRCH_A: state_next = S_SRCH_B;
            S_SRCH_B:
                if (hit)
                    state_next = S_BEGIN;
                else if (final_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SRCH;
            S_BEGIN:  state_next = S_GAP;
            S_GAP:    state_next = (k_reg == n_reg) ? S_IPI : S_GAP;
            S_IPI:    state_next = S_IPI_W;
            S_IPI_W:  state_next = S_IPJ;
            S_IPJ:
                if (j_reg == n_reg)
                    state_next = S_TERM;
                else if (j_reg == i_reg)
                    state_next = S_IPJ;
                else
                    state_next = S_IPJ_W;
            S_IPJ_W:  state_next = S_DIV;
            S_DIV:    state_next = div_done ? S_MUL : S_DIV;
            S_MUL:    state_next = S_RND;
            S_RND:    state_next = S_IPJ;
            S_TERM:   state_next = S_ACC;
            S_ACC:    state_next = (i_reg + PW'(1) == n_reg) ? S_FIN : S_IPI;
            S_FIN:    state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        rd_addr   = '0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:   mem_we = start && (op == OP_APPEND) && app_ok;
            S_SRCH:   rd_addr = AW'(((left_reg < right_reg) ? mid_c : left_reg) - CW'(1));
            S_SRCH_A: rd_addr = AW'(mid_reg);
            S_GAP:    rd_addr = AW'(begin_reg + CW'(k_reg));
            S_IPI:    rd_addr = AW'(begin_reg + CW'(i_reg));
            S_IPJ:    rd_addr = AW'(begin_reg + CW'(j_reg));
            S_IPJ_W:  div_start = 1'b1;
            default:  rd_addr = '0;
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = state_reg == S_DONE;
    assign result_value = res_reg;
    assign status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            num_points_reg <= NUM_POINTS_RST[3:0];
            max_gap_reg    <= MAX_GAP_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_POINTS: num_points_reg <= cfg_wdata[3:0];
                    CFG_MAX_GAP:    max_gap_reg    <= cfg_wdata;
                    default:        max_gap_reg    <= max_gap_reg;
                endcase
            end
            if (state_reg == S_IDLE && start)
            begin
                if (op == OP_CLEAR)
                    count_reg <= '0;
                else if (mem_we)
                    count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    t_reg      <= time_ms;
                    n_reg      <= n_eff;
                    left_reg   <= CW'(1);
                    right_reg  <= count_reg - CW'(1);
                    final_reg  <= 1'b0;
                    res_reg    <= '0;
                    status_reg <= ST_OK;
                    if (mem_we)
                    begin
                        last_reg <= time_ms;
                        if (count_reg == '0)
                            first_reg <= time_ms;
                    end
                    if (op == OP_APPEND)
                    begin
                        if (app_full)
                            status_reg <= ST_FULL;
                        else if (app_order)
                            status_reg <= ST_SPAN;
                    end
                    else if (op == OP_QUERY)
                    begin
                        if (early_few)
                            status_reg <= ST_FEW;
                        else if (early_span)
                            status_reg <= ST_SPAN;
                    end
                end
            S_SRCH:
                if (left_reg < right_reg)
                    mid_reg <= mid_c;
                else if (left_reg == right_reg)
                begin
                    mid_reg   <= left_reg;
                    final_reg <= 1'b1;
                end
                else
                    status_reg <= ST_NOTFOUND;
            S_SRCH_A:
                a_reg <= rd_time;
            S_SRCH_B:
                if (hit)
                    pos_reg <= mid_reg - CW'(1);
                else if (final_reg)
                    status_reg <= ST_NOTFOUND;
                else if (t_reg < a_reg)
                    right_reg <= mid_reg - CW'(1);
                else
                    left_reg <= mid_reg + CW'(1);
            S_BEGIN:
            begin
                if ({1'b0, pos_reg} + (CW+1)'(1) < half)
                    begin_reg <= '0;
                else if ({1'b0, pos_reg} + halfup >= {1'b0, count_reg})
                    begin_reg <= count_reg - CW'(n_reg);
                else
                    begin_reg <= CW'({1'b0, pos_reg} + (CW+1)'(1) - half);
                k_reg   <= '0;
                gap_reg <= '0;
                i_reg   <= '0;
                acc_reg <= '0;
            end
            S_GAP:
            begin
                k_reg    <= k_reg + PW'(1);
                prev_reg <= rd_time;
                if (k_reg >= PW'(2) && (rd_time - prev_reg) > gap_reg)
                    gap_reg <= rd_time - prev_reg;
            end
            S_IPI_W:
            begin
                ti_reg <= rd_time;
                vi_reg <= rd_val;
                w_reg  <= VAL_W'(32'sd1 <<< FRAC_BITS);
                j_reg  <= '0;
            end
            S_IPJ:
                if (j_reg == i_reg)
                    j_reg <= j_reg + PW'(1);
            S_IPJ_W:
                fneg_reg <= num_neg != den_neg;
            S_MUL:
                prod_reg <= 64'(w_reg) * 64'(fq);
            S_RND:
            begin
                w_reg <= sat_mag(round_q(prod_reg));
                j_reg <= j_reg + PW'(1);
            end
            S_TERM:
                prod_reg <= 64'(vi_reg) * 64'(w_reg);
            S_ACC:
            begin
                if (acc_sum > ACC_LIMIT)
                    acc_reg <= 64'(ACC_LIMIT);
                else if (acc_sum < -ACC_LIMIT)
                    acc_reg <= 64'(-ACC_LIMIT);
                else
                    acc_reg <= acc_sum[63:0];
                i_reg <= i_reg + PW'(1);
            end
            S_FIN:
            begin
                if (fin_r > 64'sd2147483647)
                    res_reg <= 32'sh7fffffff;
                else if (fin_r < -64'sd2147483648)
                    res_reg <= 32'sh80000000;
                else
                    res_reg <= fin_r[31:0];
                status_reg <= ({8'd0, max_gap_reg} < gap_reg) ? ST_GAP : ST_OK;
            end
            default:
                res_reg <= res_reg;
        endcase
    end

endmodule
